>>> rtl/env_sensor_compensation_defines.svh
// Assertion macros shared by the compensation block.
// Used by env_sensor_compensation.sv; no other dependencies.
`ifndef ENV_SENSOR_COMPENSATION_DEFINES_SVH
`define ENV_SENSOR_COMPENSATION_DEFINES_SVH

// same-cycle implication, masked during reset
`define ESC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("esc assertion failed");

// next-cycle implication, masked during reset
`define ESC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("esc assertion failed");

`endif

>>> rtl/esc_pkg.sv
// Types, constants and helper functions of the sensor compensation block.
// No dependencies; used by esc_div, esc_datapath and env_sensor_compensation.
`timescale 1ns / 1ps

package esc_pkg;

   typedef enum logic [2:0] {
      CSR_TEMP      = 3'd0,
      CSR_PRESS_LO  = 3'd1,
      CSR_PRESS_HI  = 3'd2,
      CSR_MIXED     = 3'd3,
      CSR_HUM       = 3'd4
   } csr_index_type;

   localparam logic [31:0] TEMP_OFS    = 32'd64000;
   localparam logic [31:0] PRESS_BASE  = 32'd1048576;
   localparam logic [31:0] PRESS_SCALE = 32'd3125;
   localparam logic [31:0] HUM_TOFS    = 32'd76800;
   localparam logic [31:0] HUM_MAX     = 32'd419430400;
   localparam logic [31:0] HUM_K_OFS   = 32'd2097152;
   localparam logic [31:0] RND_16384   = 32'd16384;
   localparam logic [31:0] RND_32768   = 32'd32768;
   localparam logic [31:0] RND_8192    = 32'd8192;
   localparam logic [31:0] RND_128     = 32'd128;

   typedef struct packed {
      logic [19:0] raw_pressure;
      logic [19:0] raw_temperature;
      logic [15:0] raw_humidity;
   } req_type;

   typedef struct packed {
      logic signed [31:0] fine_temperature;
      logic signed [31:0] temperature_centi;
      logic [31:0]        pressure_pa;
      logic [16:0]        humidity_q10;
   } rsp_type;

   // calibration words, already widened to 32 bits
   typedef struct packed {
      logic [31:0] t1, t2, t3;
      logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
   } coeff_type;

   // values that ride along the divider
   typedef struct packed {
      logic [31:0] tf;
      logic [31:0] tc;
      logic [16:0] hum;
      logic        big;
      logic        dz;
   } div_side_type;

   typedef struct packed {
      logic [31:0]  rem;
      logic [31:0]  dvd;
      logic [31:0]  den;
      logic [31:0]  quo;
      div_side_type side;
   } div_stage_type;

   function automatic logic [31:0] asr(input logic [31:0] a, input logic [4:0] n);
      return $unsigned($signed(a) >>> n);
   endfunction

   function automatic logic [31:0] mulw(input logic [31:0] a, input logic [31:0] b);
      return a * b;
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sx8(input logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

endpackage

>>> rtl/esc_fifo.sv
// Small register queue used at the input and at the result side.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module esc_fifo #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             wr, rd;

   assign full  = (cnt_ff == CW'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign wr    = push && !full;
   assign rd    = pop && !empty;
   assign rdata = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      if (wr) begin
         wp_in = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (rd) begin
         rp_in = (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      cnt_in = cnt_ff + CW'(wr) - CW'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wp_ff] <= wdata;
      end
   end

endmodule

>>> rtl/esc_div.sv
// Pipelined 32-bit unsigned divider, one quotient bit per stage.
// Depends on esc_pkg for the stage and sideband types.
`timescale 1ns / 1ps

module esc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [31:0]          in_dvd,
   input  logic [31:0]          in_den,
   input  esc_pkg::div_side_type in_side,
   output logic                 out_valid,
   output logic [31:0]          out_quo,
   output esc_pkg::div_side_type out_side
);

   localparam int STAGES = 32;

   esc_pkg::div_stage_type st_ff [STAGES];
   esc_pkg::div_stage_type src   [STAGES];
   esc_pkg::div_stage_type st_in [STAGES];
   logic [STAGES-1:0]      vld_ff;

   always_comb begin
      logic [32:0] r;
      src[0] = '{rem: '0, dvd: in_dvd, den: in_den, quo: '0, side: in_side};
      for (int k = 1; k < STAGES; k++) begin
         src[k] = st_ff[k-1];
      end
      for (int k = 0; k < STAGES; k++) begin
         r = {src[k].rem, src[k].dvd[31]};
         st_in[k]     = src[k];
         st_in[k].dvd = {src[k].dvd[30:0], 1'b0};
         if (r >= {1'b0, src[k].den}) begin
            st_in[k].rem = 32'(r - {1'b0, src[k].den});
            st_in[k].quo = {src[k].quo[30:0], 1'b1};
         end else begin
            st_in[k].rem = r[31:0];
            st_in[k].quo = {src[k].quo[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < STAGES; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_quo   = st_ff[STAGES-1].quo;
   assign out_side  = st_ff[STAGES-1].side;

endmodule

>>> rtl/esc_datapath.sv
// Back end: stalling compensation pipeline, temperature, pressure, humidity.
// Depends on esc_pkg and esc_div.
`timescale 1ns / 1ps

module esc_datapath (
   input  logic               clock,
   input  logic               reset,
   input  esc_pkg::coeff_type c,
   input  logic               in_valid,
   input  esc_pkg::req_type   in_data,
   output logic               in_take,
   input  logic               out_full,
   output logic               out_valid,
   output esc_pkg::rsp_type   out_data
);

   logic        en;
   logic [11:1] vld_ff;
   logic [3:1]  pv_ff;

   logic [31:0] at, ap, ah, ta, d, tf, q, b2, xh, hclamp, pfin, pq;
   logic [31:0] s1_m1, s1_dd, s1_ap, s1_ah;
   logic [31:0] s2_v1, s2_e, s2_ap, s2_ah;
   logic [31:0] s3_tf, s3_tc, s3_a, s3_x, s3_ap, s3_ah;
   logic [31:0] s4_qq, s4_pa5, s4_pa2, s4_hx, s4_gx, s4_hh, s4_tf, s4_tc, s4_ap, s4_ah;
   logic [31:0] s5_b, s5_p3m, s5_f1, s5_g, s5_h, s5_pa5, s5_pa2, s5_tf, s5_tc, s5_ap;
   logic [31:0] s6_b3, s6_a2, s6_gh, s6_f1, s6_tf, s6_tc, s6_ap;
   logic [31:0] s7_am, s7_kh, s7_b3, s7_f1, s7_tf, s7_tc, s7_ap;
   logic [31:0] s8_div, s8_pn, s8_hx2, s8_tf, s8_tc;
   logic [31:0] s9_ss, s9_hx2, s9_dvd, s9_den, s9_tf, s9_tc;
   logic        s9_big, s9_dz;
   logic [31:0] s10_t, s10_hx2, s10_dvd, s10_den, s10_tf, s10_tc;
   logic        s10_big, s10_dz;
   logic [31:0] s11_dvd, s11_den, s11_tf, s11_tc;
   logic [16:0] s11_hum;
   logic        s11_big, s11_dz;

   logic                  dv_valid;
   logic [31:0]           dv_quo;
   esc_pkg::div_side_type dv_side, s11_side;

   logic [31:0] p1_p, p1_sq, p1_pp8, p2_p, p2_m9, p2_pp8;
   esc_pkg::div_side_type p1_side, p2_side;
   esc_pkg::rsp_type      p3_rsp;

   // hold every stage while a finished result has nowhere to go
   assign en        = !(pv_ff[3] && out_full);
   assign in_take   = en && in_valid;
   assign out_valid = pv_ff[3];
   assign out_data  = p3_rsp;

   always_comb begin
      at  = {12'b0, in_data.raw_temperature};
      ap  = {12'b0, in_data.raw_pressure};
      ah  = {16'b0, in_data.raw_humidity};
      ta  = (at >> 3) - (c.t1 << 1);
      d   = (at >> 4) - c.t1;
      tf  = s2_v1 + esc_pkg::asr(s2_e, 5'd14);
      q   = esc_pkg::asr(s3_a, 5'd2);
      b2  = s5_b + (s5_pa5 << 1);
      xh  = s10_hx2 - esc_pkg::asr(s10_t, 5'd4);
      if (xh[31]) begin
         hclamp = '0;
      end else if (xh > esc_pkg::HUM_MAX) begin
         hclamp = esc_pkg::HUM_MAX;
      end else begin
         hclamp = xh;
      end
      pq   = dv_side.big ? {dv_quo[30:0], 1'b0} : dv_quo;
      pfin = p2_p + esc_pkg::asr(esc_pkg::asr(p2_m9, 5'd12)
                                 + esc_pkg::asr(p2_pp8, 5'd13) + c.p7, 5'd4);
      s11_side = '{tf: s11_tf, tc: s11_tc, hum: s11_hum, big: s11_big, dz: s11_dz};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         pv_ff  <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[10:1], in_valid};
         pv_ff  <= {pv_ff[2:1], dv_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // temperature
         s1_m1 <= esc_pkg::mulw(ta, c.t2);
         s1_dd <= esc_pkg::mulw(d, d);
         s1_ap <= ap;
         s1_ah <= ah;

         s2_v1 <= esc_pkg::asr(s1_m1, 5'd11);
         s2_e  <= esc_pkg::mulw(esc_pkg::asr(s1_dd, 5'd12), c.t3);
         s2_ap <= s1_ap;
         s2_ah <= s1_ah;

         s3_tf <= tf;
         s3_tc <= esc_pkg::asr((tf << 2) + tf + esc_pkg::RND_128, 5'd8);
         s3_a  <= esc_pkg::asr(tf, 5'd1) - esc_pkg::TEMP_OFS;
         s3_x  <= tf - esc_pkg::HUM_TOFS;
         s3_ap <= s2_ap;
         s3_ah <= s2_ah;

         // pressure and humidity products
         s4_qq  <= esc_pkg::mulw(q, q);
         s4_pa5 <= esc_pkg::mulw(s3_a, c.p5);
         s4_pa2 <= esc_pkg::mulw(c.p2, s3_a);
         s4_hx  <= esc_pkg::mulw(c.h5, s3_x);
         s4_gx  <= esc_pkg::mulw(s3_x, c.h6);
         s4_hh  <= esc_pkg::mulw(s3_x, c.h3);
         s4_tf  <= s3_tf;
         s4_tc  <= s3_tc;
         s4_ap  <= s3_ap;
         s4_ah  <= s3_ah;

         s5_b   <= esc_pkg::mulw(esc_pkg::asr(s4_qq, 5'd11), c.p6);
         s5_p3m <= esc_pkg::mulw(c.p3, esc_pkg::asr(s4_qq, 5'd13));
         s5_f1  <= esc_pkg::asr((s4_ah << 14) - (c.h4 << 20) - s4_hx
                                + esc_pkg::RND_16384, 5'd15);
         s5_g   <= esc_pkg::asr(s4_gx, 5'd10);
         s5_h   <= esc_pkg::asr(s4_hh, 5'd11) + esc_pkg::RND_32768;
         s5_pa5 <= s4_pa5;
         s5_pa2 <= s4_pa2;
         s5_tf  <= s4_tf;
         s5_tc  <= s4_tc;
         s5_ap  <= s4_ap;

         s6_b3 <= esc_pkg::asr(b2, 5'd2) + (c.p4 << 16);
         s6_a2 <= esc_pkg::asr(esc_pkg::asr(s5_p3m, 5'd3)
                               + esc_pkg::asr(s5_pa2, 5'd1), 5'd18);
         s6_gh <= esc_pkg::mulw(s5_g, s5_h);
         s6_f1 <= s5_f1;
         s6_tf <= s5_tf;
         s6_tc <= s5_tc;
         s6_ap <= s5_ap;

         s7_am <= esc_pkg::mulw(esc_pkg::RND_32768 + s6_a2, c.p1);
         s7_kh <= esc_pkg::mulw(esc_pkg::asr(s6_gh, 5'd10) + esc_pkg::HUM_K_OFS, c.h2);
         s7_b3 <= s6_b3;
         s7_f1 <= s6_f1;
         s7_tf <= s6_tf;
         s7_tc <= s6_tc;
         s7_ap <= s6_ap;

         s8_div <= esc_pkg::asr(s7_am, 5'd15);
         s8_pn  <= esc_pkg::mulw((esc_pkg::PRESS_BASE - s7_ap)
                                 - esc_pkg::asr(s7_b3, 5'd12), esc_pkg::PRESS_SCALE);
         s8_hx2 <= esc_pkg::mulw(s7_f1, esc_pkg::asr(s7_kh + esc_pkg::RND_8192, 5'd14));
         s8_tf  <= s7_tf;
         s8_tc  <= s7_tc;

         // large numerators divide first and double afterwards
         s9_ss  <= esc_pkg::mulw(esc_pkg::asr(s8_hx2, 5'd15), esc_pkg::asr(s8_hx2, 5'd15));
         s9_hx2 <= s8_hx2;
         s9_dvd <= s8_pn[31] ? s8_pn : {s8_pn[30:0], 1'b0};
         s9_big <= s8_pn[31];
         s9_den <= s8_div;
         s9_dz  <= (s8_div == '0);
         s9_tf  <= s8_tf;
         s9_tc  <= s8_tc;

         s10_t   <= esc_pkg::mulw(esc_pkg::asr(s9_ss, 5'd7), c.h1);
         s10_hx2 <= s9_hx2;
         s10_dvd <= s9_dvd;
         s10_den <= s9_den;
         s10_big <= s9_big;
         s10_dz  <= s9_dz;
         s10_tf  <= s9_tf;
         s10_tc  <= s9_tc;

         s11_hum <= hclamp[28:12];
         s11_dvd <= s10_dvd;
         s11_den <= s10_den;
         s11_big <= s10_big;
         s11_dz  <= s10_dz;
         s11_tf  <= s10_tf;
         s11_tc  <= s10_tc;

         // pressure correction after the division
         p1_p    <= pq;
         p1_sq   <= esc_pkg::mulw(pq >> 3, pq >> 3);
         p1_pp8  <= esc_pkg::mulw(pq >> 2, c.p8);
         p1_side <= dv_side;

         p2_p    <= p1_p;
         p2_m9   <= esc_pkg::mulw(c.p9, p1_sq >> 13);
         p2_pp8  <= p1_pp8;
         p2_side <= p1_side;

         p3_rsp.fine_temperature  <= $signed(p2_side.tf);
         p3_rsp.temperature_centi <= $signed(p2_side.tc);
         p3_rsp.pressure_pa       <= p2_side.dz ? '0 : pfin;
         p3_rsp.humidity_q10      <= p2_side.hum;
      end
   end

   esc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld_ff[11]),
      .in_dvd    (s11_dvd),
      .in_den    (s11_den),
      .in_side   (s11_side),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

endmodule

>>> rtl/env_sensor_compensation.sv
// Sensor compensation block: one raw reading in, one compensated reading out
// per clock as long as results are popped. A reading passes from the input
// queue to the result queue through 11 stages of temperature, pressure and
// humidity arithmetic, a 32-stage divider for the pressure quotient (one bit
// per stage) and three stages of pressure correction. When the result queue
// fills, the whole pipeline holds in place and the input queue absorbs
// further readings. Calibration registers are to be written through the csr
// port while no reading is in flight; the block does not enforce this.
// Depends on esc_pkg, esc_fifo, esc_div, esc_datapath and the defines header.
`timescale 1ns / 1ps
`include "env_sensor_compensation_defines.svh"

module env_sensor_compensation #(
   parameter int IN_DEPTH  = 4,
   parameter int OUT_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  esc_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output esc_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_wdata
);

   localparam int REQ_W = $bits(esc_pkg::req_type);
   localparam int RSP_W = $bits(esc_pkg::rsp_type);

   logic [47:0] temp_ff, mixed_ff;
   logic [63:0] plo_ff, phi_ff;
   logic [39:0] hum_ff;

   esc_pkg::coeff_type c;
   esc_pkg::req_type   in_word;
   esc_pkg::rsp_type   dp_data;
   logic [REQ_W-1:0]   in_bits;
   logic [RSP_W-1:0]   out_bits;
   logic               in_empty, in_take, dp_valid, out_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff  <= '0;
         plo_ff   <= '0;
         phi_ff   <= '0;
         mixed_ff <= '0;
         hum_ff   <= '0;
      end else if (csr_we) begin
         unique case (esc_pkg::csr_index_type'(csr_index))
            esc_pkg::CSR_TEMP:     temp_ff  <= csr_wdata[47:0];
            esc_pkg::CSR_PRESS_LO: plo_ff   <= csr_wdata;
            esc_pkg::CSR_PRESS_HI: phi_ff   <= csr_wdata;
            esc_pkg::CSR_MIXED:    mixed_ff <= csr_wdata[47:0];
            esc_pkg::CSR_HUM:      hum_ff   <= csr_wdata[39:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      c.t1 = {16'b0, temp_ff[15:0]};
      c.t2 = esc_pkg::sx16(temp_ff[31:16]);
      c.t3 = esc_pkg::sx16(temp_ff[47:32]);
      c.p1 = {16'b0, plo_ff[15:0]};
      c.p2 = esc_pkg::sx16(plo_ff[31:16]);
      c.p3 = esc_pkg::sx16(plo_ff[47:32]);
      c.p4 = esc_pkg::sx16(plo_ff[63:48]);
      c.p5 = esc_pkg::sx16(phi_ff[15:0]);
      c.p6 = esc_pkg::sx16(phi_ff[31:16]);
      c.p7 = esc_pkg::sx16(phi_ff[47:32]);
      c.p8 = esc_pkg::sx16(phi_ff[63:48]);
      c.p9 = esc_pkg::sx16(mixed_ff[15:0]);
      c.h1 = {24'b0, mixed_ff[23:16]};
      c.h2 = esc_pkg::sx16(mixed_ff[39:24]);
      c.h3 = {24'b0, mixed_ff[47:40]};
      c.h4 = esc_pkg::sx16(hum_ff[15:0]);
      c.h5 = esc_pkg::sx16(hum_ff[31:16]);
      c.h6 = esc_pkg::sx8(hum_ff[39:32]);
   end

   esc_fifo #(.DEPTH(IN_DEPTH), .WIDTH(REQ_W)) u_in_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (req_data),
      .full  (req_full),
      .pop   (in_take),
      .rdata (in_bits),
      .empty (in_empty)
   );

   assign in_word = esc_pkg::req_type'(in_bits);

   esc_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .c         (c),
      .in_valid  (!in_empty),
      .in_data   (in_word),
      .in_take   (in_take),
      .out_full  (out_full),
      .out_valid (dp_valid),
      .out_data  (dp_data)
   );

   esc_fifo #(.DEPTH(OUT_DEPTH), .WIDTH(RSP_W)) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (dp_valid),
      .wdata (dp_data),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (out_bits),
      .empty (rsp_empty)
   );

   assign rsp_data = esc_pkg::rsp_type'(out_bits);

   `ESC_ASSERT_NEXT(a_stall_holds, clock, reset, dp_valid && out_full, dp_valid && $stable(dp_data))
   `ESC_ASSERT_NEXT(a_word_queued, clock, reset, req_push && !req_full, !in_empty)
   `ESC_ASSERT_NOW(a_take_only_valid, clock, reset, in_take, !in_empty)

endmodule
